### hw/rtl/atoc_pkg.sv
// Shared types, constants and tables for the accelerometer tilt classifier.
package atoc_pkg;

  localparam int SAMPLE_W = 16;
  localparam int WORK_W   = 24;          // filtered value with 8 fraction bits
  localparam int SQ_W     = 49;          // sum of up to three squares
  localparam int SQRT_TOP = 48;          // highest even bit of the radicand
  localparam int SQRT_STEPS = SQRT_TOP / 2 + 1;
  localparam int CORD_W   = 28;
  localparam int ANG_W    = 26;
  localparam int STEP_W   = 5;
  localparam int ATAN_LEN = 24;

  localparam logic [SQ_W-1:0] TINY_ENERGY    = SQ_W'(64'd17592186);
  localparam logic [SQ_W-1:0] TINY_MAGNITUDE = SQ_W'(64'd1759218604);

  localparam logic signed [ANG_W-1:0] ANG_P90 = ANG_W'(90 * 65536);
  localparam logic signed [ANG_W-1:0] ANG_N90 = -ANG_W'(90 * 65536);

  localparam logic [21:0] ATAN_Q16 [ATAN_LEN] = '{
    22'd2949120, 22'd1740967, 22'd919879, 22'd466945, 22'd234379, 22'd117304,
    22'd58666, 22'd29335, 22'd14668, 22'd7334, 22'd3667, 22'd1833,
    22'd917, 22'd458, 22'd229, 22'd115, 22'd57, 22'd29,
    22'd14, 22'd7, 22'd4, 22'd2, 22'd1, 22'd0
  };

  // Configuration register indexes
  localparam logic [2:0] CFG_OFFSET_X   = 3'd0;
  localparam logic [2:0] CFG_OFFSET_Y   = 3'd1;
  localparam logic [2:0] CFG_OFFSET_Z   = 3'd2;
  localparam logic [2:0] CFG_FILTER_GAIN = 3'd3;
  localparam logic [2:0] CFG_TILT_THR   = 3'd4;
  localparam logic [2:0] CFG_VERT_LIMIT = 3'd5;

  // Axis / angle job indexes
  localparam logic [1:0] JOB_PITCH = 2'd0;
  localparam logic [1:0] JOB_ROLL  = 2'd1;
  localparam logic [1:0] JOB_VERT  = 2'd2;

  localparam logic [2:0] CLS_VERTICAL   = 3'd0;
  localparam logic [2:0] CLS_HORIZONTAL = 3'd1;
  localparam logic [2:0] CLS_SLIGHT     = 3'd2;
  localparam logic [2:0] CLS_HIGH       = 3'd3;
  localparam logic [2:0] CLS_INVERTED   = 3'd4;

  localparam logic [2:0] DIR_NONE     = 3'd0;
  localparam logic [2:0] DIR_FORWARD  = 3'd1;
  localparam logic [2:0] DIR_BACKWARD = 3'd2;
  localparam logic [2:0] DIR_RIGHT    = 3'd3;
  localparam logic [2:0] DIR_LEFT     = 3'd4;
  localparam logic [2:0] DIR_DIAGONAL = 3'd5;

  typedef enum logic [3:0] {
    ST_IDLE, ST_FMUL, ST_FADD, ST_SQ, ST_SLOAD, ST_SQRT,
    ST_CLOAD, ST_CSTEP, ST_STORE, ST_FIN
  } state_t;

  typedef struct packed {
    logic               accept;
    logic               filt_mul;
    logic               filt_add;
    logic               square;
    logic               sqrt_load;
    logic               sqrt_step;
    logic               cord_load;
    logic               cord_step;
    logic               store;
    logic               finish;
    logic [1:0]         idx;
    logic [STEP_W-1:0]  step;
  } ctrl_cmd_t;

  typedef struct packed {
    logic signed [15:0] offset_x;
    logic signed [15:0] offset_y;
    logic signed [15:0] offset_z;
    logic [15:0]        filter_gain;
    logic [14:0]        tilt_threshold;
    logic [13:0]        vertical_limit;
  } cfg_t;

endpackage

### hw/rtl/atoc_ctrl.sv
// Sequencer for the filter, square, square-root and CORDIC steps.
module atoc_ctrl
  import atoc_pkg::*;
#(
  parameter int CORDIC_STEPS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  output ctrl_cmd_t  cmd
);

  localparam logic [STEP_W-1:0] CORD_LAST = STEP_W'(CORDIC_STEPS - 1);
  localparam logic [STEP_W-1:0] SQRT_LAST = STEP_W'(SQRT_STEPS - 1);

  state_t            state_r, state_nxt;
  logic [1:0]        idx_r, idx_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    step_nxt  = step_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_FMUL;
          idx_nxt   = 2'd0;
        end
      end
      ST_FMUL: state_nxt = ST_FADD;
      ST_FADD: begin
        if (idx_r == JOB_VERT) begin
          state_nxt = ST_SQ;
          idx_nxt   = 2'd0;
        end else begin
          state_nxt = ST_FMUL;
          idx_nxt   = idx_r + 2'd1;
        end
      end
      ST_SQ: begin
        if (idx_r == JOB_VERT) begin
          state_nxt = ST_SLOAD;
          idx_nxt   = JOB_PITCH;
        end else begin
          idx_nxt = idx_r + 2'd1;
        end
      end
      ST_SLOAD: begin
        state_nxt = ST_SQRT;
        step_nxt  = '0;
      end
      ST_SQRT: begin
        if (step_r == SQRT_LAST) state_nxt = ST_CLOAD;
        else step_nxt = step_r + STEP_W'(1);
      end
      ST_CLOAD: begin
        state_nxt = ST_CSTEP;
        step_nxt  = '0;
      end
      ST_CSTEP: begin
        if (step_r == CORD_LAST) state_nxt = ST_STORE;
        else step_nxt = step_r + STEP_W'(1);
      end
      ST_STORE: begin
        if (idx_r == JOB_VERT) begin
          state_nxt = ST_FIN;
        end else begin
          state_nxt = ST_SLOAD;
          idx_nxt   = idx_r + 2'd1;
        end
      end
      ST_FIN: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd           = '0;
    cmd.idx       = idx_r;
    cmd.step      = step_r;
    in_ready      = (state_r == ST_IDLE);
    cmd.accept    = (state_r == ST_IDLE) && in_valid;
    cmd.filt_mul  = (state_r == ST_FMUL);
    cmd.filt_add  = (state_r == ST_FADD);
    cmd.square    = (state_r == ST_SQ);
    cmd.sqrt_load = (state_r == ST_SLOAD);
    cmd.sqrt_step = (state_r == ST_SQRT);
    cmd.cord_load = (state_r == ST_CLOAD);
    cmd.cord_step = (state_r == ST_CSTEP);
    cmd.store     = (state_r == ST_STORE);
    cmd.finish    = (state_r == ST_FIN) && out_free;
  end

  // Result register: set on finish, drop on transfer
  always_comb begin
    if (cmd.finish) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

### hw/rtl/atoc_dp.sv
// Datapath: offset, smoothing filter, squares, shared square root and CORDIC.
module atoc_dp
  import atoc_pkg::*;
#(
  parameter int FILTER_FRAC_BITS = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  ctrl_cmd_t           cmd,
  input  cfg_t                cfg,
  input  logic signed [15:0]  in_x,
  input  logic signed [15:0]  in_y,
  input  logic signed [15:0]  in_z,
  output logic signed [15:0]  smooth_x,
  output logic signed [15:0]  smooth_y,
  output logic signed [15:0]  smooth_z,
  output logic signed [15:0]  pitch_deg,
  output logic signed [15:0]  roll_deg,
  output logic [15:0]         vert_deg,
  output logic [2:0]          orient_cls,
  output logic [2:0]          tilt_dir
);

  localparam int FW  = SAMPLE_W + FILTER_FRAC_BITS;
  localparam int PW  = FW + 18;
  localparam int SHR = (FILTER_FRAC_BITS >= 8) ? FILTER_FRAC_BITS - 8 : 0;
  localparam int SHL = (FILTER_FRAC_BITS < 8) ? 8 - FILTER_FRAC_BITS : 0;

  logic signed [15:0]       d_r [3];
  logic signed [FW-1:0]     filt_r [3];
  logic signed [PW-1:0]     prod_r;
  logic signed [PW-1:0]     prod;
  logic signed [FW-1:0]     tgt;
  logic signed [FW:0]       diff;
  logic signed [WORK_W-1:0] w [3];
  logic signed [WORK_W-1:0] w_sel;
  logic [SQ_W-1:0]          sq_r [3];
  logic signed [2*WORK_W-1:0] sq_prod;
  logic [SQ_W-1:0]          s_yz, s_xz, s_xy, s_all;

  logic [SQ_W:0]            rem_r, root_r, bit_r, trial;
  logic [SQ_W-1:0]          rad;

  logic signed [CORD_W-1:0] cx_r, cy_r, x0, y0, xs, ys, rootv;
  logic signed [ANG_W-1:0]  ang_r, ang_rnd, q;
  logic signed [15:0]       pitch_r, roll_r;
  logic [15:0]              vert_r;
  logic                     ok;
  logic signed [15:0]       res;

  logic signed [15:0]       sm_x_r, sm_y_r, sm_z_r, pitch_o_r, roll_o_r;
  logic [15:0]              vert_o_r;
  logic [2:0]               cls_r, dir_r, cls, dir;
  logic [15:0]              ap, ar, thr;

  // Filter: one axis at a time through one multiplier, a multiply step then an add step
  assign tgt  = FW'(d_r[cmd.idx]) <<< FILTER_FRAC_BITS;
  assign diff = (FW+1)'(tgt) - (FW+1)'(filt_r[cmd.idx]);
  assign prod = $signed({1'b0, cfg.filter_gain}) * diff;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      d_r[0] <= in_x - cfg.offset_x;
      d_r[1] <= in_y - cfg.offset_y;
      d_r[2] <= in_z - cfg.offset_z;
    end
    if (cmd.filt_mul) prod_r <= prod;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filt_r[0] <= '0;
      filt_r[1] <= '0;
      filt_r[2] <= '0;
    end else if (cmd.filt_add) begin
      filt_r[cmd.idx] <= filt_r[cmd.idx] + FW'(prod_r >>> 16);
    end
  end

  for (genvar a = 0; a < 3; a++) begin : g_work
    assign w[a] = WORK_W'(filt_r[a] >>> SHR) <<< SHL;
  end

  // Squares, one axis per cycle
  assign w_sel   = w[cmd.idx];
  assign sq_prod = w_sel * w_sel;

  always_ff @(posedge clk) begin
    if (cmd.square) sq_r[cmd.idx] <= SQ_W'(unsigned'(sq_prod));
  end

  assign s_yz  = sq_r[1] + sq_r[2];
  assign s_xz  = sq_r[0] + sq_r[2];
  assign s_xy  = sq_r[0] + sq_r[1];
  assign s_all = s_xy + sq_r[2];

  // Integer square root, one result bit per cycle
  always_comb begin
    case (cmd.idx)
      JOB_PITCH: rad = s_yz;
      JOB_ROLL:  rad = s_xz;
      default:   rad = s_xy;
    endcase
  end

  assign trial = root_r + bit_r;

  always_ff @(posedge clk) begin
    if (cmd.sqrt_load) begin
      rem_r  <= {1'b0, rad};
      root_r <= '0;
      bit_r  <= (SQ_W+1)'(1) << SQRT_TOP;
    end else if (cmd.sqrt_step) begin
      if (rem_r >= trial) begin
        rem_r  <= rem_r - trial;
        root_r <= (root_r >> 1) + bit_r;
      end else begin
        root_r <= root_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
  end

  // CORDIC vectoring, one iteration per cycle
  assign rootv = CORD_W'(root_r);

  always_comb begin
    case (cmd.idx)
      JOB_PITCH: begin
        y0 = CORD_W'(w[0]);
        x0 = rootv;
      end
      JOB_ROLL: begin
        y0 = CORD_W'(w[1]);
        x0 = rootv;
      end
      default: begin
        y0 = rootv;
        x0 = CORD_W'(w[2]);
      end
    endcase
  end

  assign xs = cx_r >>> cmd.step;
  assign ys = cy_r >>> cmd.step;

  always_ff @(posedge clk) begin
    if (cmd.cord_load) begin
      if (x0 < 0) begin
        if (y0 >= 0) begin
          cx_r  <= y0;
          cy_r  <= -x0;
          ang_r <= ANG_P90;
        end else begin
          cx_r  <= -y0;
          cy_r  <= x0;
          ang_r <= ANG_N90;
        end
      end else begin
        cx_r  <= x0;
        cy_r  <= y0;
        ang_r <= '0;
      end
    end else if (cmd.cord_step) begin
      if (cy_r >= 0) begin
        cx_r  <= cx_r + ys;
        cy_r  <= cy_r - xs;
        ang_r <= ang_r + ANG_W'(ATAN_Q16[cmd.step]);
      end else begin
        cx_r  <= cx_r - ys;
        cy_r  <= cy_r + xs;
        ang_r <= ang_r - ANG_W'(ATAN_Q16[cmd.step]);
      end
    end
  end

  // Round to Q8.8, clamp, and zero when the energy test fails
  assign ang_rnd = ang_r + ANG_W'(128);
  assign q       = ang_rnd >>> 8;

  always_comb begin
    case (cmd.idx)
      JOB_PITCH: ok = (s_yz > TINY_ENERGY);
      JOB_ROLL:  ok = (s_xz > TINY_ENERGY);
      default:   ok = (s_all > TINY_MAGNITUDE);
    endcase
    if (cmd.idx == JOB_VERT) begin
      if (q < 0) res = '0;
      else if (q > ANG_W'(46080)) res = 16'(46080);
      else res = 16'(q);
    end else begin
      if (q < -ANG_W'(23040)) res = -16'sd23040;
      else if (q > ANG_W'(23040)) res = 16'sd23040;
      else res = 16'(q);
    end
    if (!ok) res = '0;
  end

  always_ff @(posedge clk) begin
    if (cmd.store) begin
      case (cmd.idx)
        JOB_PITCH: pitch_r <= res;
        JOB_ROLL:  roll_r  <= res;
        default:   vert_r  <= res;
      endcase
    end
  end

  // Classification
  assign ap  = (pitch_r < 0) ? 16'(-pitch_r) : 16'(pitch_r);
  assign ar  = (roll_r < 0) ? 16'(-roll_r) : 16'(roll_r);
  assign thr = 16'(cfg.tilt_threshold);

  always_comb begin
    if (vert_r <= 16'(cfg.vertical_limit)) cls = CLS_VERTICAL;
    else if (vert_r inside {[16'd18432:16'd27648]}) cls = CLS_HORIZONTAL;
    else if (vert_r <= 16'd11520) cls = CLS_SLIGHT;
    else if (vert_r <= 16'd18432) cls = CLS_HIGH;
    else cls = CLS_INVERTED;

    if (ap > thr && ar < thr) dir = (pitch_r > 0) ? DIR_FORWARD : DIR_BACKWARD;
    else if (ar > thr && ap < thr) dir = (roll_r > 0) ? DIR_RIGHT : DIR_LEFT;
    else if (ap > thr && ar > thr) dir = DIR_DIAGONAL;
    else dir = DIR_NONE;
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      sm_x_r    <= 16'(filt_r[0] >>> FILTER_FRAC_BITS);
      sm_y_r    <= 16'(filt_r[1] >>> FILTER_FRAC_BITS);
      sm_z_r    <= 16'(filt_r[2] >>> FILTER_FRAC_BITS);
      pitch_o_r <= pitch_r;
      roll_o_r  <= roll_r;
      vert_o_r  <= vert_r;
      cls_r     <= cls;
      dir_r     <= dir;
    end
  end

  assign smooth_x   = sm_x_r;
  assign smooth_y   = sm_y_r;
  assign smooth_z   = sm_z_r;
  assign pitch_deg  = pitch_o_r;
  assign roll_deg   = roll_o_r;
  assign vert_deg   = vert_o_r;
  assign orient_cls = cls_r;
  assign tilt_dir   = dir_r;

endmodule

### hw/rtl/accel_tilt_orientation_classifier_top.sv
// Accelerometer tilt and orientation classifier, top level.
// One three-axis sample per transfer gives one result: smoothed axes, pitch,
// roll and angle from vertical in Q8.8 degrees, plus orientation class and
// tilt direction. Each item uses one shared square-root unit and one shared
// CORDIC, each run three times per item. A finished result waits in an
// output register, so the next sample is taken while it is still pending.
// Configuration writes are taken any time the block is idle.
module accel_tilt_orientation_classifier_top
  import atoc_pkg::*;
#(
  parameter int CORDIC_STEPS     = 16,
  parameter int FILTER_FRAC_BITS = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] in_sample_x,
  input  logic signed [15:0] in_sample_y,
  input  logic signed [15:0] in_sample_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_smooth_x,
  output logic signed [15:0] out_smooth_y,
  output logic signed [15:0] out_smooth_z,
  output logic signed [15:0] out_pitch_deg,
  output logic signed [15:0] out_roll_deg,
  output logic [15:0]        out_vertical_angle_deg,
  output logic [2:0]         out_orientation_class,
  output logic [2:0]         out_tilt_direction,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  cfg_t      cfg_r;
  ctrl_cmd_t cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.offset_x       <= '0;
      cfg_r.offset_y       <= '0;
      cfg_r.offset_z       <= '0;
      cfg_r.filter_gain    <= 16'd13107;
      cfg_r.tilt_threshold <= 15'd3072;
      cfg_r.vertical_limit <= 14'd4608;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_OFFSET_X:    cfg_r.offset_x       <= cfg_data;
        CFG_OFFSET_Y:    cfg_r.offset_y       <= cfg_data;
        CFG_OFFSET_Z:    cfg_r.offset_z       <= cfg_data;
        CFG_FILTER_GAIN: cfg_r.filter_gain    <= cfg_data;
        CFG_TILT_THR:    cfg_r.tilt_threshold <= cfg_data[14:0];
        CFG_VERT_LIMIT:  cfg_r.vertical_limit <= cfg_data[13:0];
        default: ;
      endcase
    end
  end

  atoc_ctrl #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  atoc_dp #(
    .FILTER_FRAC_BITS(FILTER_FRAC_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .cfg        (cfg_r),
    .in_x       (in_sample_x),
    .in_y       (in_sample_y),
    .in_z       (in_sample_z),
    .smooth_x   (out_smooth_x),
    .smooth_y   (out_smooth_y),
    .smooth_z   (out_smooth_z),
    .pitch_deg  (out_pitch_deg),
    .roll_deg   (out_roll_deg),
    .vert_deg   (out_vertical_angle_deg),
    .orient_cls (out_orientation_class),
    .tilt_dir   (out_tilt_direction)
  );

endmodule
